/* rtl/core/assert_macros.svh */
// assertion macros used by the spcud_check checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define SPCUD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define SPCUD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/spcud_pkg.sv */
// ----------------------------------------------------------------------------
// spcud_pkg
// Types and constants of the shared-pair cluster union and dedup core.
// ----------------------------------------------------------------------------
`default_nettype none

package spcud_pkg;

   localparam int ID_W          = 16;
   localparam int CLUSTER_N     = 6;
   localparam int UNION_N       = 10;
   localparam int SHARED_NEEDED = 2;
   localparam int TABLE_DEPTH   = 1024;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int STATUS_W      = 2;

   // per-cluster match counts and row hit sums
   localparam int PAIR_HIT_W = $clog2(CLUSTER_N + 1);
   localparam int SHARED_W   = $clog2(CLUSTER_N * CLUSTER_N + 1);
   localparam int ROW_HIT_W  = $clog2(UNION_N + 1);
   localparam int ROW_SUM_W  = $clog2(UNION_N * UNION_N + 1);
   localparam int EXTRA_N    = UNION_N - CLUSTER_N;
   localparam int PLACE_W    = $clog2(EXTRA_N + 1);

   // stream payload widths
   localparam int REQ_BITS = 2 * CLUSTER_N * ID_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STATUS_W + IDX_W + UNION_N * ID_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [ID_W-1:0] id_type;
   typedef logic [CLUSTER_N-1:0][ID_W-1:0] cluster_type;
   typedef logic [UNION_N-1:0][ID_W-1:0] row_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NOT_TWO = 2'd0,
      ST_DUP     = 2'd1,
      ST_ADDED   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/shared_pair_cluster_union_dedup_core.sv */
// ----------------------------------------------------------------------------
// shared_pair_cluster_union_dedup_core
// Merges two six-member clusters into a ten-member union and keeps a table of
// distinct unions for pairs that share exactly two members.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one transfer carries clusters A and B (twelve 16-bit ids).
//   rsp channel: one transfer per request with status, table index and union.
//   The union table lives in a 1024 x 160-bit synchronous RAM. A pair with two
//   shared members is checked against the stored rows in order until one
//   matches, one row read per cycle; rows are compared in a three-stage
//   pipeline (read, per-member match counts, row sum).
//   The next request is taken from the cycle after the result is parked in
//   the output register, so the core works on one item at a time; for a pair
//   with two shared members the row scan sets the throughput.
//   Reset empties the table (the row count goes to zero, no RAM clearing
//   pass is needed) and drops any pending response.
//   A stalled response is held in the output register; the core still takes
//   and works on one more request and waits to hand over its result until
//   the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_pair_cluster_union_dedup_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // req_tdata: a_member_0..a_member_5, b_member_0..b_member_5 (16 bits each)
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [spcud_pkg::REQ_W-1:0] req_tdata,
   // rsp_tdata: status[1:0], entry_index[11:2], union_0..union_9 (16 bits
   // each from bit 12), zero pad
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [spcud_pkg::RSP_W-1:0]    rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PREP,
      S_SCAN,
      S_DONE
   } state_type;

   // control state
   state_type                       state_ff, state_in;
   logic [spcud_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [spcud_pkg::CNT_W-1:0]     ptr_ff, ptr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spcud_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   spcud_pkg::status_type           res_status_ff, res_status_in;
   logic [spcud_pkg::IDX_W-1:0]     res_idx_ff, res_idx_in;

   // item payload
   spcud_pkg::cluster_type          a_ff, b_ff;
   spcud_pkg::row_type              union_ff;
   spcud_pkg::row_type              union_c;
   logic [spcud_pkg::SHARED_W-1:0]  shared_c;

   // scan pipeline
   logic                            issue;
   logic                            wr_en;
   spcud_pkg::row_type              mem [spcud_pkg::TABLE_DEPTH];
   spcud_pkg::row_type              rd_row_ff;
   logic                            rv_ff;
   logic [spcud_pkg::IDX_W-1:0]     ridx_ff;
   logic [spcud_pkg::UNION_N-1:0][spcud_pkg::ROW_HIT_W-1:0] counts_ff;
   logic [spcud_pkg::UNION_N-1:0][spcud_pkg::ROW_HIT_W-1:0] counts_c;
   logic                            cv_ff;
   logic [spcud_pkg::IDX_W-1:0]     cidx_ff;
   logic [spcud_pkg::ROW_SUM_W-1:0] row_sum_c;
   logic                            hit;
   logic                            scan_end;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared count and union of the held pair
   always_comb begin
      logic [spcud_pkg::CLUSTER_N-1:0]  eq;
      logic [spcud_pkg::PAIR_HIT_W-1:0] hits;
      logic [spcud_pkg::PLACE_W-1:0]    placed;
      union_c  = '0;
      shared_c = '0;
      placed   = '0;
      eq       = '0;
      hits     = '0;
      for (int k = 0; k < spcud_pkg::CLUSTER_N; k++) begin
         union_c[k] = b_ff[k];
      end
      for (int i = 0; i < spcud_pkg::CLUSTER_N; i++) begin
         for (int x = 0; x < spcud_pkg::CLUSTER_N; x++) begin
            eq[x] = (a_ff[i] == b_ff[x]);
         end
         hits     = spcud_pkg::PAIR_HIT_W'($countones(eq));
         shared_c = shared_c + spcud_pkg::SHARED_W'(hits);
         if ((hits == '0) && (placed < spcud_pkg::PLACE_W'(spcud_pkg::EXTRA_N))) begin
            for (int k = 0; k < spcud_pkg::EXTRA_N; k++) begin
               if (placed == spcud_pkg::PLACE_W'(k)) begin
                  union_c[spcud_pkg::CLUSTER_N + k] = a_ff[i];
               end
            end
            placed = placed + 1'b1;
         end
      end
   end

   // per-member match counts of the row just read
   always_comb begin
      logic [spcud_pkg::UNION_N-1:0] eq;
      eq = '0;
      for (int r = 0; r < spcud_pkg::UNION_N; r++) begin
         for (int q = 0; q < spcud_pkg::UNION_N; q++) begin
            eq[q] = (rd_row_ff[q] == union_ff[r]);
         end
         counts_c[r] = spcud_pkg::ROW_HIT_W'($countones(eq));
      end
   end

   // row sum; a row matches when exactly ten pairs are equal
   always_comb begin
      row_sum_c = '0;
      for (int r = 0; r < spcud_pkg::UNION_N; r++) begin
         row_sum_c = row_sum_c + spcud_pkg::ROW_SUM_W'(counts_ff[r]);
      end
   end

   assign hit      = cv_ff && (row_sum_c == spcud_pkg::ROW_SUM_W'(spcud_pkg::UNION_N));
   assign issue    = (state_ff == S_SCAN) && (ptr_ff < cnt_ff);
   assign scan_end = (ptr_ff == cnt_ff) && !rv_ff && !cv_ff;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;

      // output register drains on a transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            ptr_in = '0;
            if (shared_c == spcud_pkg::SHARED_W'(spcud_pkg::SHARED_NEEDED)) begin
               state_in = S_SCAN;
            end else begin
               res_status_in = spcud_pkg::ST_NOT_TWO;
               res_idx_in    = '0;
               state_in      = S_DONE;
            end
         end
         S_SCAN: begin
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (hit) begin
               res_status_in = spcud_pkg::ST_DUP;
               res_idx_in    = cidx_ff;
               state_in      = S_DONE;
            end else if (scan_end) begin
               if (cnt_ff == spcud_pkg::CNT_W'(spcud_pkg::TABLE_DEPTH)) begin
                  res_status_in = spcud_pkg::ST_FULL;
                  res_idx_in    = '0;
               end else begin
                  wr_en         = 1'b1;
                  res_status_in = spcud_pkg::ST_ADDED;
                  res_idx_in    = cnt_ff[spcud_pkg::IDX_W-1:0];
                  cnt_in        = cnt_ff + 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(spcud_pkg::RSP_W - spcud_pkg::RSP_BITS){1'b0}},
                               union_ff, res_idx_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         ptr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= spcud_pkg::ST_NOT_TWO;
         res_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_idx_ff    <= res_idx_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // scan pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         cv_ff <= 1'b0;
      end else begin
         rv_ff <= issue;
         cv_ff <= rv_ff && (state_ff == S_SCAN);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_ff <= req_tdata[0 +: spcud_pkg::CLUSTER_N * spcud_pkg::ID_W];
         b_ff <= req_tdata[spcud_pkg::CLUSTER_N * spcud_pkg::ID_W +:
                           spcud_pkg::CLUSTER_N * spcud_pkg::ID_W];
      end
      if (state_ff == S_PREP) begin
         union_ff <= union_c;
      end
      ridx_ff   <= ptr_ff[spcud_pkg::IDX_W-1:0];
      counts_ff <= counts_c;
      cidx_ff   <= ridx_ff;
   end

   // union table, one row read or written per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[spcud_pkg::IDX_W-1:0]] <= union_ff;
      end
      if (issue) begin
         rd_row_ff <= mem[ptr_ff[spcud_pkg::IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/spcud_check.sv */
// ----------------------------------------------------------------------------
// spcud_check
// Port-level checks of the shared-pair cluster union and dedup core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spcud_check (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [spcud_pkg::RSP_W-1:0] rsp_tdata
);

   // reset drops any pending response
   `SPCUD_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "response valid after reset")

   // one item at a time: the core is busy right after taking a request
   `SPCUD_ASSERT(a_busy_after_req, (req_tvalid && req_tready) |=> !req_tready, "request taken while busy")

   // a new response only follows a busy cycle of the core
   `SPCUD_ASSERT(a_rsp_after_work, $rose(rsp_tvalid) |-> $past(!req_tready), "response without work")

   // a stalled response holds
   `SPCUD_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled response changed")

endmodule

bind shared_pair_cluster_union_dedup_core spcud_check u_spcud_check (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared-pair cluster union and dedup core.
// A table of hand-picked pairs runs first, then randomized pairs that grow the
// union table and replay earlier unions. Every response is compared field by
// field against an in-bench model of the shared count, the union and the
// table lookup, with random stalls on both streams.
// ----------------------------------------------------------------------------

module tb_top;
   import spcud_pkg::*;

   localparam int IDLE_PCT      = 13;
   localparam int RANDOM_ITEMS  = 564;
   localparam int LONG_HOLD     = 400;
   localparam int STALL_LIMIT   = 8000;
   localparam int SETTLE_CYCLES = 50;
   localparam int MAX_REPORTS   = 40;
   localparam int DIRECTED_ROWS = 16;

   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    index;
      row_type             members;
   } union_result;

   typedef struct packed {
      cluster_type a;
      cluster_type b;
   } cluster_pair;

   // ids are A members 0..5 then B members 0..5
   typedef struct {
      id_type     ids [2*CLUSTER_N];
      bit         typed;
      status_type status;
      int         index;
   } directed_case;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // model state: stored unions and their count
   row_type     known_unions [TABLE_DEPTH];
   int          known_count = 0;
   union_result pending_unions [$];
   cluster_pair overlap_history [$];
   union_result oldest_union;

   int errors          = 0;
   int status_seen [4] = '{default: 0};
   bit steady_run      = 1'b0;
   int hold_asked      = 0;
   int hold_done       = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;

   // hand-picked pairs; status and slot typed in where obvious
   directed_case directed_cases [DIRECTED_ROWS] = '{
      // two shared on an empty table
      '{'{1, 2, 3, 4, 5, 6, 1, 2, 7, 8, 9, 10}, 1'b1, ST_ADDED, 0},
      // same union, both clusters reordered
      '{'{3, 4, 5, 6, 1, 2, 10, 9, 8, 7, 2, 1}, 1'b1, ST_DUP, 0},
      // nothing shared
      '{'{11, 12, 13, 14, 15, 16, 21, 22, 23, 24, 25, 26}, 1'b1, ST_NOT_TWO, 0},
      // three shared, last union slot left at zero
      '{'{1, 2, 3, 31, 32, 33, 1, 2, 3, 41, 42, 43}, 1'b1, ST_NOT_TWO, 0},
      // all ids at the low and high ends
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ST_NOT_TWO, 0},
      '{'{'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
          'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF}, 1'b1, ST_NOT_TWO, 0},
      // shared members at both range ends
      '{'{0, 'hFFFF, 1, 2, 3, 4, 'hFFFF, 0, 5, 6, 7, 8}, 1'b1, ST_ADDED, 1},
      // repeated id in B, five unshared A members, first four kept
      '{'{100, 101, 102, 103, 104, 105, 100, 100, 200, 201, 202, 203}, 1'b1, ST_ADDED, 2},
      // repeated id in A
      '{'{300, 300, 301, 302, 303, 304, 300, 400, 401, 402, 403, 404}, 1'b1, ST_ADDED, 3},
      // A and B swapped against the first union
      '{'{7, 8, 9, 10, 1, 2, 1, 2, 3, 4, 5, 6}, 1'b1, ST_DUP, 0},
      // alternating bit patterns
      '{'{'hAAAA, 'h5555, 'h0F0F, 'hF0F0, 'h00FF, 'hFF00,
          'h5555, 'hAAAA, 'h3333, 'hCCCC, 'h6666, 'h9999}, 1'b0, ST_NOT_TWO, 0},
      // second stored union, reordered
      '{'{1, 2, 3, 4, 0, 'hFFFF, 5, 6, 7, 8, 0, 'hFFFF}, 1'b1, ST_DUP, 1},
      // repeat of the repeated-id union: pair count over the rows is not ten
      '{'{100, 101, 102, 103, 104, 105, 100, 100, 200, 201, 202, 203}, 1'b0, ST_NOT_TWO, 0},
      // union with a repeated id hitting the first row exactly ten times
      '{'{1, 6, 7, 8, 9, 10, 1, 1, 2, 3, 4, 5}, 1'b0, ST_NOT_TWO, 0},
      // one shared
      '{'{50, 51, 52, 53, 54, 55, 50, 60, 61, 62, 63, 64}, 1'b1, ST_NOT_TWO, 0},
      // all six shared
      '{'{1, 2, 3, 4, 5, 6, 6, 5, 4, 3, 2, 1}, 1'b1, ST_NOT_TWO, 0}
   };

   shared_pair_cluster_union_dedup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // expected union, status and slot of one pair; updates the union table
   function automatic union_result fold_pair(cluster_type a, cluster_type b);
      union_result res;
      int          shared;
      int          fill;
      int          hits;
      int          row_hits;
      bit          found;
      res.status  = ST_NOT_TWO;
      res.index   = '0;
      res.members = '0;
      shared      = 0;
      fill        = CLUSTER_N;
      found       = 1'b0;
      for (int i = 0; i < CLUSTER_N; i++) res.members[i] = b[i];
      // count equal pairs, keep unshared A members in A's order
      for (int i = 0; i < CLUSTER_N; i++) begin
         hits = 0;
         for (int x = 0; x < CLUSTER_N; x++)
            if (a[i] == b[x]) hits++;
         shared += hits;
         if (hits == 0 && fill < UNION_N) begin
            res.members[fill] = a[i];
            fill++;
         end
      end
      if (shared != SHARED_NEEDED) return res;
      // a stored row matches when exactly ten member pairs are equal
      for (int r = 0; r < known_count && !found; r++) begin
         row_hits = 0;
         for (int p = 0; p < UNION_N; p++)
            for (int q = 0; q < UNION_N; q++)
               if (known_unions[r][q] == res.members[p]) row_hits++;
         if (row_hits == UNION_N) begin
            found     = 1'b1;
            res.index = IDX_W'(r);
         end
      end
      if (found) begin
         res.status = ST_DUP;
      end else if (known_count >= TABLE_DEPTH) begin
         res.status = ST_FULL;
      end else begin
         known_unions[known_count] = res.members;
         res.index  = IDX_W'(known_count);
         res.status = ST_ADDED;
         known_count++;
      end
      return res;
   endfunction

   function automatic cluster_type shuffled(cluster_type c);
      id_type t;
      int     j;
      for (int i = CLUSTER_N - 1; i > 0; i--) begin
         j    = $urandom_range(0, i);
         t    = c[i];
         c[i] = c[j];
         c[j] = t;
      end
      return c;
   endfunction

   function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
   endfunction

   // random pair: fresh two-shared union, replay of an earlier one, other
   // overlap counts, small alphabets with repeats, or plain noise
   task automatic pick_item(input int fresh_pct, input int replay_pct,
                            output cluster_type a, output cluster_type b);
      int          roll;
      int          kind_roll;
      int          k;
      bit          clash;
      id_type      pool [2*CLUSTER_N];
      cluster_pair p;
      roll      = $urandom_range(0, 99);
      kind_roll = $urandom_range(0, 9);
      if (roll >= fresh_pct && roll < fresh_pct + replay_pct && overlap_history.size() > 0) begin
         p = overlap_history[$urandom_range(0, overlap_history.size() - 1)];
         // swapping A and B keeps the union set
         if ($urandom_range(0, 1)) begin
            a = p.b;
            b = p.a;
         end else begin
            a = p.a;
            b = p.b;
         end
         a = shuffled(a);
         b = shuffled(b);
      end else if (roll < fresh_pct || kind_roll < 4) begin
         // k distinct ids common to both clusters
         if (roll < fresh_pct) begin
            k = SHARED_NEEDED;
         end else begin
            k = $urandom_range(0, CLUSTER_N - 1);
            if (k >= SHARED_NEEDED) k++;
         end
         for (int i = 0; i < 2*CLUSTER_N - k; i++) begin
            do begin
               pool[i] = id_type'($urandom);
               clash   = 1'b0;
               for (int j = 0; j < i; j++)
                  if (pool[j] == pool[i]) clash = 1'b1;
            end while (clash);
         end
         for (int i = 0; i < CLUSTER_N; i++) begin
            a[i] = pool[i];
            b[i] = (i < k) ? pool[i] : pool[CLUSTER_N + i - k];
         end
         a = shuffled(a);
         b = shuffled(b);
         if (k == SHARED_NEEDED) begin
            p.a = a;
            p.b = b;
            overlap_history.push_back(p);
         end
      end else if (kind_roll < 7) begin
         // few distinct ids near either end of the range
         for (int i = 0; i < CLUSTER_N; i++) begin
            a[i] = id_type'($urandom_range(0, 5));
            b[i] = id_type'($urandom_range(0, 5));
         end
         if ($urandom_range(0, 1)) begin
            a = ~a;
            b = ~b;
         end
      end else begin
         for (int i = 0; i < CLUSTER_N; i++) begin
            a[i] = id_type'($urandom);
            b[i] = id_type'($urandom);
         end
      end
   endtask

   // one request transfer; the expectation is queued at acceptance
   task automatic send_pair(input cluster_type a, input cluster_type b, input bit typed,
                            input status_type typed_status, input int typed_index);
      union_result want;
      if (!steady_run)
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tdata  <= {b, a};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = fold_pair(a, b);
      if (typed) begin
         want.status = typed_status;
         want.index  = IDX_W'(typed_index);
      end
      pending_unions.push_back(want);
   endtask

   // stop offering until every queued result has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_unions.size() != 0);
   endtask

   // stimulus
   initial begin
      cluster_type a;
      cluster_type b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_cases[n]) begin
         for (int i = 0; i < CLUSTER_N; i++) begin
            a[i] = directed_cases[n].ids[i];
            b[i] = directed_cases[n].ids[CLUSTER_N + i];
         end
         send_pair(a, b, directed_cases[n].typed, directed_cases[n].status,
                   directed_cases[n].index);
      end
      wait_for_drain();

      // random mix, one long output stall and a stretch with no idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) hold_asked <= hold_asked + 1;
         if (n == 200) steady_run <= 1'b1;
         if (n == 350) steady_run <= 1'b0;
         pick_item(40, 25, a, b);
         send_pair(a, b, 1'b0, ST_NOT_TWO, 0);
      end
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("tb_top: %0d pairs checked: %0d not two shared, %0d duplicate, %0d added, %0d full",
               status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
               status_seen[ST_NOT_TWO], status_seen[ST_DUP], status_seen[ST_ADDED],
               status_seen[ST_FULL]);
      $display("tb_top: union table reached %0d of %0d rows, one %0d-cycle output stall",
               known_count, TABLE_DEPTH, LONG_HOLD);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // response side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_unions.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t ns: result transfer with no pair pending, expected none, got %h",
                           $time, rsp_tdata);
            end else begin
               oldest_union = pending_unions.pop_front();
               status_seen[oldest_union.status]++;
               if (rsp_tdata[STATUS_W-1:0] !== oldest_union.status)
                  report_field("status", oldest_union.status, rsp_tdata[STATUS_W-1:0]);
               if (rsp_tdata[STATUS_W +: IDX_W] !== oldest_union.index)
                  report_field("entry_index", oldest_union.index, rsp_tdata[STATUS_W +: IDX_W]);
               for (int k = 0; k < UNION_N; k++)
                  if (rsp_tdata[STATUS_W + IDX_W + k*ID_W +: ID_W] !== oldest_union.members[k])
                     report_field($sformatf("union_%0d", k), oldest_union.members[k],
                                  rsp_tdata[STATUS_W + IDX_W + k*ID_W +: ID_W]);
               if (rsp_tdata[RSP_W-1:RSP_BITS] !== '0)
                  report_field("pad", 0, rsp_tdata[RSP_W-1:RSP_BITS]);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end
   end

endmodule
